@@ hw/rtl/ilp_pkg.sv @@
package ilp_pkg;

    localparam int VALUE_BITS = 64;
    localparam int OUT_W      = 64;

    localparam logic [2:0] MODE_BIN  = 3'd0;
    localparam logic [2:0] MODE_OCT  = 3'd1;
    localparam logic [2:0] MODE_UDEC = 3'd2;
    localparam logic [2:0] MODE_SDEC = 3'd3;
    localparam logic [2:0] MODE_HEX  = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FORMAT  = 2'd1;
    localparam logic [1:0] ST_ILLEGAL = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    // error flag bit positions
    localparam int EF_FMT = 0;
    localparam int EF_ILL = 1;
    localparam int EF_OVF = 2;

    // digit limits for the shift radices
    localparam int BIN_DMAX = VALUE_BITS;
    localparam int OCT_DMAX = (VALUE_BITS + 2) / 3;
    localparam int OCT_TOP  = VALUE_BITS - 3 * (OCT_DMAX - 1);
    localparam int HEX_DMAX = (VALUE_BITS + 3) / 4;
    localparam int HEX_TOP  = VALUE_BITS - 4 * (HEX_DMAX - 1);

    typedef logic [VALUE_BITS-1:0] acc_t;

    // 16 means not a digit in any radix
    function automatic logic [4:0] digit_of(input logic [7:0] c);
        logic [4:0] d;
        d = 5'd16;
        if (c >= "0" && c <= "9")
            d = 5'(c - 8'h30);
        else if (c >= "a" && c <= "f")
            d = 5'(c - 8'h61 + 8'd10);
        else if (c >= "A" && c <= "F")
            d = 5'(c - 8'h41 + 8'd10);
        return d;
    endfunction

    function automatic logic is_prefixed(input logic [2:0] m);
        return (m == MODE_BIN) || (m == MODE_OCT) || (m == MODE_HEX);
    endfunction

    function automatic logic [4:0] radix_of(input logic [2:0] m);
        logic [4:0] r;
        case (m)
            MODE_BIN: r = 5'd2;
            MODE_OCT: r = 5'd8;
            MODE_HEX: r = 5'd16;
            default:  r = 5'd10;
        endcase
        return r;
    endfunction

endpackage

@@ hw/rtl/integer_literal_parser.sv @@
// channel  | valid      | stall      | payload
// ---------+------------+------------+--------------------------
// request  | req_valid  | req_stall  | req_type, ch, last
// result   | res_valid  | res_stall  | value, status
//
// one character per cycle while req_stall is low; a word goes into an input
// register, then the parse state and the result register update from it
// a last character reaches res_valid via the input and result registers
// rst_n clears all parse state and both valid flags
// req_stall rises only when a last character waits on a full, stalled
// result register; other characters never wait
module integer_literal_parser
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    req_valid,
    output logic                    req_stall,
    input  logic [2:0]              req_type,
    input  logic [7:0]              ch,
    input  logic                    last,
    output logic                    res_valid,
    input  logic                    res_stall,
    output logic [ilp_pkg::OUT_W-1:0] value,
    output logic [1:0]              status
);
    import ilp_pkg::*;

    localparam logic [1:0] PH_PREFIX = 2'd0;
    localparam logic [1:0] PH_SIGN   = 2'd1;
    localparam logic [1:0] PH_ZERO   = 2'd2;
    localparam logic [1:0] PH_DIGIT  = 2'd3;

    localparam int WIDE_W = VALUE_BITS + 4;

    // input register
    logic       in_v_reg;
    logic [2:0] in_type_reg;
    logic [7:0] in_ch_reg;
    logic       in_last_reg;

    // parse state
    acc_t       acc_reg, acc_next;
    logic [1:0] pos_reg, pos_next;
    logic [6:0] cnt_reg, cnt_next;
    logic [1:0] phase_reg, phase_next;
    logic [7:0] first_reg, first_next;
    logic       neg_reg, neg_next;
    logic [2:0] mode_reg, mode_next;
    logic [2:0] err_reg, err_next;

    // result register
    logic               out_v_reg;
    logic [OUT_W-1:0]   value_reg, value_next;
    logic [1:0]         status_reg, status_next;

    logic out_free;
    logic advance;

    logic [4:0]        dig;
    logic [WIDE_W-1:0] acc_x10;
    logic [WIDE_W-1:0] dec_sum;
    acc_t              dec_lim;
    logic              dec_ovf;

    assign out_free  = !out_v_reg || !res_stall;
    assign advance   = in_v_reg && (!in_last_reg || out_free);
    assign req_stall = in_v_reg && !advance;

    // decimal step: acc*10 + d against the limit
    assign dig     = digit_of(in_ch_reg);
    assign acc_x10 = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0};
    assign dec_sum = acc_x10 + WIDE_W'(dig);

    always_comb
    begin
        logic       done;
        logic [7:0] want;
        logic [4:0] radix;
        logic [4:0] fdig;
        logic       pfx_ovf;
        acc_t       neg_val;

        mode_next  = mode_reg;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        first_next = first_reg;
        neg_next   = neg_reg;
        err_next   = err_reg;
        acc_next   = acc_reg;
        pos_next   = pos_reg;
        done       = 1'b0;
        want       = 8'h78;
        pfx_ovf    = 1'b0;

        if (pos_reg == 2'd0)
        begin
            if (in_type_reg > MODE_HEX)
            begin
                err_next[EF_FMT] = 1'b1;
                mode_next = MODE_UDEC;
            end
            else
            begin
                mode_next = in_type_reg;
            end
            if (is_prefixed(mode_next))
                phase_next = PH_PREFIX;
            else if (mode_next == MODE_SDEC)
                phase_next = PH_SIGN;
            else
                phase_next = PH_ZERO;
        end

        if (in_ch_reg == 8'h00)
            err_next[EF_FMT] = 1'b1;

        if (phase_next == PH_PREFIX)
        begin
            if (pos_reg == 2'd0)
            begin
                if (in_ch_reg != "0")
                    err_next[EF_FMT] = 1'b1;
            end
            else
            begin
                case (mode_next)
                    MODE_BIN: want = "b";
                    MODE_OCT: want = "o";
                    default:  want = "x";
                endcase
                if ((in_ch_reg | 8'h20) != want)
                    err_next[EF_FMT] = 1'b1;
                phase_next = PH_ZERO;
            end
            done = 1'b1;
        end

        if (!done && phase_next == PH_SIGN)
        begin
            if (in_ch_reg == "-" && !in_last_reg)
            begin
                neg_next = !neg_reg;
                done = 1'b1;
            end
            else
            begin
                phase_next = PH_ZERO;
            end
        end

        if (!done && phase_next == PH_ZERO)
        begin
            if (in_ch_reg == "0" && !in_last_reg)
                done = 1'b1;
            else
                phase_next = PH_DIGIT;
        end

        radix = radix_of(mode_next);
        dec_lim = (mode_next == MODE_SDEC) ? {1'b0, {(VALUE_BITS-1){1'b1}}}
                                           : {VALUE_BITS{1'b1}};
        dec_ovf = dec_sum > WIDE_W'(dec_lim);
        if (!done)
        begin
            if (cnt_reg == 7'd0)
                first_next = in_ch_reg;
            if (cnt_reg != 7'd127)
                cnt_next = cnt_reg + 7'd1;
            if (dig >= radix)
                err_next[EF_ILL] = 1'b1;
            else if (radix == 5'd10)
            begin
                if (dec_ovf)
                    err_next[EF_OVF] = 1'b1;
                else
                    acc_next = dec_sum[VALUE_BITS-1:0];
            end
            else
            begin
                case (mode_next)
                    MODE_BIN: acc_next = {acc_reg[VALUE_BITS-2:0], dig[0]};
                    MODE_OCT: acc_next = {acc_reg[VALUE_BITS-4:0], dig[2:0]};
                    default:  acc_next = {acc_reg[VALUE_BITS-5:0], dig[3:0]};
                endcase
            end
        end

        if (pos_reg != 2'd2)
            pos_next = pos_reg + 2'd1;

        // final status from the updated state
        if (is_prefixed(mode_next) && pos_reg != 2'd2)
            err_next[EF_FMT] = err_next[EF_FMT] | in_last_reg;

        fdig = digit_of(first_next);
        case (mode_next)
            MODE_BIN:
                pfx_ovf = cnt_next > 7'(BIN_DMAX);
            MODE_OCT:
                pfx_ovf = (cnt_next > 7'(OCT_DMAX)) ||
                          ((cnt_next == 7'(OCT_DMAX)) && (OCT_TOP < 3) &&
                           (fdig >= 5'(1 << OCT_TOP)));
            MODE_HEX:
                pfx_ovf = (cnt_next > 7'(HEX_DMAX)) ||
                          ((cnt_next == 7'(HEX_DMAX)) && (HEX_TOP < 4) &&
                           (fdig >= 5'(1 << HEX_TOP)));
            default:
                pfx_ovf = 1'b0;
        endcase

        if (err_next[EF_FMT])
            status_next = ST_FORMAT;
        else if (is_prefixed(mode_next))
        begin
            if (pfx_ovf)
                status_next = ST_OVERFLOW;
            else if (err_next[EF_ILL])
                status_next = ST_ILLEGAL;
            else
                status_next = ST_OK;
        end
        else if (err_next[EF_ILL])
            status_next = ST_ILLEGAL;
        else if (err_next[EF_OVF])
            status_next = ST_OVERFLOW;
        else
            status_next = ST_OK;

        neg_val = acc_t'(~acc_next + acc_t'(1));
        if (status_next != ST_OK)
            value_next = '0;
        else if (neg_next)
            value_next = OUT_W'(neg_val);
        else
            value_next = OUT_W'(acc_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
        end
        else if (!req_stall)
        begin
            in_v_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!req_stall)
        begin
            in_type_reg <= req_type;
            in_ch_reg   <= ch;
            in_last_reg <= last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            pos_reg   <= 2'd0;
            cnt_reg   <= 7'd0;
            phase_reg <= PH_PREFIX;
            first_reg <= 8'd0;
            neg_reg   <= 1'b0;
            mode_reg  <= MODE_BIN;
            err_reg   <= 3'd0;
        end
        else if (advance)
        begin
            if (in_last_reg)
            begin
                acc_reg   <= '0;
                pos_reg   <= 2'd0;
                cnt_reg   <= 7'd0;
                phase_reg <= PH_PREFIX;
                first_reg <= 8'd0;
                neg_reg   <= 1'b0;
                mode_reg  <= MODE_BIN;
                err_reg   <= 3'd0;
            end
            else
            begin
                acc_reg   <= acc_next;
                pos_reg   <= pos_next;
                cnt_reg   <= cnt_next;
                phase_reg <= phase_next;
                first_reg <= first_next;
                neg_reg   <= neg_next;
                mode_reg  <= mode_next;
                err_reg   <= err_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (advance && in_last_reg)
        begin
            out_v_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            value_reg  <= value_next;
            status_reg <= status_next;
        end
    end

    assign res_valid = out_v_reg;
    assign value     = value_reg;
    assign status    = status_reg;

    // an errored word never carries a value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg && status_reg != ST_OK |-> value_reg == '0)
        else $error("nonzero value with error status");

    // only a last character can wait for the result register
    assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> in_v_reg && in_last_reg && out_v_reg)
        else $error("stall without a pending last character");

    // a finished literal leaves clean state behind
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_last_reg |=> pos_reg == 2'd0 && cnt_reg == 7'd0 &&
                                   err_reg == 3'd0 && !neg_reg)
        else $error("state not cleared after last character");

    assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg != 2'd3)
        else $error("character position past saturation");

endmodule
